// ===== src/base64url_stream_codec_assert.svh =====
// Assertion macros shared by the codec modules. They expect clk and rst in scope.
`ifndef BASE64URL_STREAM_CODEC_ASSERT_SVH
`define BASE64URL_STREAM_CODEC_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64U_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/b64u_pkg.sv =====
package b64u_pkg;

  localparam int MaxResults = 4;
  localparam int CountW = 3;
  localparam int IdxW = 2;
  localparam int PaddrW = 3;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [0:0] RegDirectionMode = 1'b0;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [7:0] in_value;
    logic       value_present;
    logic       stream_end;
  } item_t;

  typedef struct packed {
    logic [7:0] out_value;
    logic       run_last;
  } result_t;

  typedef struct packed {
    logic [CountW-1:0]           count;
    logic [MaxResults-1:0][7:0]  values;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] sym;
  } sym_t;

  function automatic logic [7:0] sym_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return w + 8'h41;
    end else if (v < 6'd52) begin
      return w + 8'h47;
    end else if (v < 6'd62) begin
      return w - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2D;
    end else begin
      return 8'h5F;
    end
  endfunction

  function automatic sym_t char_sym(input logic [7:0] c);
    sym_t       r;
    logic [7:0] t;
    r = '0;
    t = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
      r.ok = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'd71;
      r.ok = 1'b1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c + 8'd4;
      r.ok = 1'b1;
    end else if (c == 8'h2D) begin
      t = 8'd62;
      r.ok = 1'b1;
    end else if (c == 8'h5F) begin
      t = 8'd63;
      r.ok = 1'b1;
    end
    r.sym = t[5:0];
    return r;
  endfunction

endpackage

// ===== src/b64u_front.sv =====
module b64u_front
  import b64u_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    mode,
  input  logic    item_valid,
  input  logic    item_stall,
  input  item_t   item,
  output logic    push,
  output bundle_t bundle
);

  logic [11:0] acc, acc_next;
  logic [3:0]  pend, pend_next;
  logic [1:0]  phase, phase_next;
  logic        halted, halted_next;
  logic [CountW-1:0] n_res;
  logic [MaxResults-1:0][7:0] vals;
  logic        accept;

  assign accept = item_valid && !item_stall;

  always_comb begin
    sym_t        sv;
    logic [11:0] tmp;
    logic [3:0]  shamt;
    acc_next = acc;
    pend_next = pend;
    phase_next = phase;
    halted_next = halted;
    n_res = '0;
    vals = '0;
    sv = '0;
    tmp = '0;
    shamt = '0;
    if (mode == ModeEncode) begin
      if (item.value_present) begin
        acc_next = {acc_next[3:0], item.in_value};
        pend_next = pend_next + 4'd8;
        for (int k = 0; k < 2; k++) begin
          if (pend_next >= 4'd6) begin
            shamt = pend_next - 4'd6;
            tmp = acc_next >> shamt;
            vals[n_res[IdxW-1:0]] = sym_char(tmp[5:0]);
            n_res = n_res + 3'd1;
            pend_next = pend_next - 4'd6;
            phase_next = phase_next + 2'd1;
          end
        end
      end
      if (item.stream_end) begin
        if (pend_next != 4'd0) begin
          shamt = 4'd6 - pend_next;
          tmp = acc_next << shamt;
          vals[n_res[IdxW-1:0]] = sym_char(tmp[5:0]);
          n_res = n_res + 3'd1;
          phase_next = phase_next + 2'd1;
        end
        for (int k = 0; k < 3; k++) begin
          if (phase_next != 2'd0 && n_res < 3'(MaxResults)) begin
            vals[n_res[IdxW-1:0]] = PadChar;
            n_res = n_res + 3'd1;
            phase_next = phase_next + 2'd1;
          end
        end
      end
    end else begin
      if (item.value_present && !halted) begin
        sv = char_sym(item.in_value);
        if (!sv.ok) begin
          halted_next = 1'b1;
        end else begin
          acc_next = {acc_next[5:0], sv.sym};
          pend_next = pend_next + 4'd6;
          if (pend_next >= 4'd8) begin
            shamt = pend_next - 4'd8;
            tmp = acc_next >> shamt;
            vals[0] = tmp[7:0];
            n_res = 3'd1;
            pend_next = pend_next - 4'd8;
          end
        end
      end
    end
    if (item.stream_end) begin
      acc_next = '0;
      pend_next = '0;
      phase_next = '0;
      halted_next = 1'b0;
    end
  end

  assign push = accept && (n_res != '0);
  assign bundle.count = n_res;
  assign bundle.values = vals;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      pend <= '0;
      phase <= '0;
      halted <= 1'b0;
    end else if (accept) begin
      acc <= acc_next;
      pend <= pend_next;
      phase <= phase_next;
      halted <= halted_next;
    end
  end

endmodule

// ===== src/b64u_queue.sv =====
`include "base64url_stream_codec_assert.svh"

module b64u_queue
  import b64u_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output bundle_t q_data
);

  bundle_t    mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `B64U_ASSERT_SAME(a_no_overflow, push, !full, "queue written while full")
  `B64U_ASSERT_SAME(a_no_underflow, pop, q_valid, "queue read while empty")

endmodule

// ===== src/b64u_back.sv =====
`include "base64url_stream_codec_assert.svh"

module b64u_back
  import b64u_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    q_valid,
  input  bundle_t q_data,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  bundle_t         cur;
  logic            busy;
  logic [IdxW-1:0] idx;
  logic            last;
  logic            adv;

  assign last = ({1'b0, idx} == cur.count - 3'd1);
  assign adv = busy && !result_stall;
  assign pop = q_valid && (!busy || (adv && last));

  assign result_valid = busy;
  assign result.out_value = cur.values[idx];
  assign result.run_last = last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx <= '0;
    end else if (pop) begin
      busy <= 1'b1;
      idx <= '0;
    end else if (adv) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  `B64U_ASSERT_SAME(a_idx_in_range, busy, ({1'b0, idx} < cur.count), "result index past count")
  `B64U_ASSERT_NEXT(a_drain_idle, adv && last && !q_valid, !busy,
                    "output stayed valid after last result with nothing queued")

endmodule

// ===== src/base64url_stream_codec.sv =====
// Channel   Valid          Stall          Payload
// item      item_valid     item_stall     item   (item_t: in_value, value_present, stream_end)
// result    result_valid   result_stall   result (result_t: out_value, run_last)
// config    APB write at psel & penable & pwrite; register 0 is direction_mode.
//
// One transaction enters per cycle while the two-entry bundle queue has room.
// The output stage sends one result per cycle unless result_stall holds it; an item makes
// up to four results.
// Reset is synchronous and clears the codec state, the queue and the mode register.
// result_stall holds the output stage; item_stall rises only when the queue is full.
module base64url_stream_codec
  import b64u_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic    mode;
  logic    push, full, pop, q_valid;
  bundle_t push_data, q_data;
  logic    reg_hit;

  assign pready = 1'b1;
  assign reg_hit = (paddr[PaddrW-1:PaddrW-1] == RegDirectionMode);
  assign prdata = reg_hit ? {31'b0, mode} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeEncode;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      mode <= pwdata[0];
    end
  end

  assign item_stall = full;

  b64u_front u_front (
    .clk        (clk),
    .rst        (rst),
    .mode       (mode),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .bundle     (push_data)
  );

  b64u_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  b64u_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ===== bench/base64url_stream_codec_checker.sv =====
`timescale 1ns / 1ps

module base64url_stream_codec_checker
  import b64u_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  item_t             item,
  input  logic              result_valid,
  input  logic              result_stall,
  input  result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                mismatches,
  output int                outstanding,
  output int                results_checked
);

  localparam logic [PaddrW-1:0] ModeRegAddr = PaddrW'(4 * RegDirectionMode);

  logic       mode;
  logic [11:0] acc;
  logic [3:0] pend;
  logic [1:0] phase;
  logic       halted;

  logic [7:0] burst[MaxResults];
  int         burst_len;
  result_t    expected_chars[$];
  int         err_cnt;
  int         checked_cnt;

  function automatic logic [7:0] symbol_to_ascii(input logic [5:0] s);
    if (s < 6'd26) return 8'("A") + 8'(s);
    if (s < 6'd52) return 8'("a") + 8'(s - 6'd26);
    if (s < 6'd62) return 8'("0") + 8'(s - 6'd52);
    if (s == 6'd62) return 8'("-");
    return 8'("_");
  endfunction

  // The top bit flags a character that belongs to the alphabet.
  function automatic logic [6:0] ascii_to_symbol(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return {1'b1, 6'(c - 8'("A"))};
    if (c >= "a" && c <= "z") return {1'b1, 6'(c - 8'("a") + 8'd26)};
    if (c >= "0" && c <= "9") return {1'b1, 6'(c - 8'("0") + 8'd52)};
    if (c == "-") return {1'b1, 6'd62};
    if (c == "_") return {1'b1, 6'd63};
    return 7'd0;
  endfunction

  function automatic void add_output(input logic [7:0] v);
    if (burst_len < MaxResults) begin
      burst[burst_len] = v;
      burst_len++;
    end
  endfunction

  task automatic predict_transaction(input item_t it);
    logic [6:0] dec;
    result_t    r;
    burst_len = 0;
    if (mode == ModeEncode) begin
      if (it.value_present) begin
        acc = {acc[3:0], it.in_value};
        pend = pend + 4'd8;
        while (pend >= 4'd6) begin
          add_output(symbol_to_ascii(6'(acc >> (pend - 4'd6))));
          pend = pend - 4'd6;
          phase = phase + 2'd1;
        end
      end
      if (it.stream_end) begin
        if (pend != 4'd0) begin
          add_output(symbol_to_ascii(6'(acc << (4'd6 - pend))));
          phase = phase + 2'd1;
        end
        while (phase != 2'd0 && burst_len < MaxResults) begin
          add_output(PadChar);
          phase = phase + 2'd1;
        end
      end
    end else if (it.value_present && !halted) begin
      dec = ascii_to_symbol(it.in_value);
      if (it.in_value == PadChar || !dec[6]) begin
        halted = 1'b1;
      end else begin
        acc = {acc[5:0], dec[5:0]};
        pend = pend + 4'd6;
        if (pend >= 4'd8) begin
          add_output(8'(acc >> (pend - 4'd8)));
          pend = pend - 4'd8;
        end
      end
    end
    if (it.stream_end) begin
      acc = '0;
      pend = '0;
      phase = '0;
      halted = 1'b0;
    end
    for (int i = 0; i < burst_len; i++) begin
      r.out_value = burst[i];
      r.run_last = (i == burst_len - 1);
      expected_chars.insert(expected_chars.size(), r);
    end
  endtask

  task automatic report_error(input string msg);
    if (err_cnt < 10) $display("%t ERROR: %s", $realtime, msg);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      mode = ModeEncode;
      acc = '0;
      pend = '0;
      phase = '0;
      halted = 1'b0;
      expected_chars.delete();
      err_cnt = 0;
      checked_cnt = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ModeRegAddr) begin
        mode = pwdata[0];
      end
      if (item_valid && !item_stall) begin
        predict_transaction(item);
      end
      if (result_valid && !result_stall) begin
        checked_cnt++;
        if (expected_chars.size() == 0) begin
          report_error($sformatf("unexpected result out_value %02h run_last %b",
                                 result.out_value, result.run_last));
        end else begin
          exp_r = expected_chars.pop_front();
          if (result.out_value !== exp_r.out_value || result.run_last !== exp_r.run_last) begin
            report_error($sformatf(
                "expected out_value %02h run_last %b, got out_value %02h run_last %b",
                exp_r.out_value, exp_r.run_last, result.out_value, result.run_last));
          end
        end
      end
    end
    mismatches <= err_cnt;
    outstanding <= expected_chars.size();
    results_checked <= checked_cnt;
  end

endmodule

// ===== bench/base64url_stream_codec_tb.sv =====
`timescale 1ns / 1ps

module base64url_stream_codec_tb
  import b64u_pkg::*;
;

  localparam logic [PaddrW-1:0] ModeRegAddr = PaddrW'(4 * RegDirectionMode);
  localparam string Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  localparam int RandomPerRegime = 145;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  item_t             item = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  result_t           result;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches;
  int outstanding;
  int results_checked;

  int   tx_pct = 0;
  int   rx_pct = 0;
  logic cur_mode = ModeEncode;
  int   encode_items = 0;
  int   decode_items = 0;
  int   stream_ends = 0;
  int   mode_writes = 0;

  always #5 clk = ~clk;

  base64url_stream_codec dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  base64url_stream_codec_checker codec_monitor (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatches(mismatches), .outstanding(outstanding),
    .results_checked(results_checked)
  );

  always @(posedge clk) begin
    result_stall <= (rx_pct != 0) && ($urandom_range(99) < rx_pct);
  end

  task automatic push(input logic [7:0] value, input logic present, input logic last);
    int gap;
    gap = 0;
    while (tx_pct != 0 && gap < 20 && $urandom_range(99) < tx_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= '{in_value: value, value_present: present, stream_end: last};
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    if (cur_mode == ModeEncode) encode_items++;
    else decode_items++;
    if (last) stream_ends++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ModeRegAddr;
    pwdata <= {31'($urandom()), m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cur_mode = m;
    mode_writes++;
  endtask

  function automatic logic [7:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (cur_mode == ModeEncode || r < 3) return 8'($urandom_range(255));
    if (r < 6) return PadChar;
    return Alphabet[$urandom_range(63)];
  endfunction

  initial begin
    int r;
    int useful;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_mode(ModeEncode);
    push(8'hA5, 1'b0, 1'b0);
    push(8'h00, 1'b0, 1'b1);
    push(8'h00, 1'b1, 1'b0);
    push(8'hFF, 1'b1, 1'b0);
    push(8'hFB, 1'b1, 1'b1);
    push(8'hFF, 1'b1, 1'b1);
    push(8'hFB, 1'b1, 1'b0);
    push(8'hEF, 1'b1, 1'b0);
    push(8'hBE, 1'b1, 1'b0);
    push(8'h00, 1'b0, 1'b1);

    write_mode(ModeDecode);
    push("A", 1'b1, 1'b0);
    push("z", 1'b1, 1'b0);
    push("0", 1'b1, 1'b0);
    push("_", 1'b1, 1'b0);
    push("-", 1'b1, 1'b0);
    push("9", 1'b1, 1'b0);
    push(8'h00, 1'b0, 1'b1);
    push("Q", 1'b1, 1'b0);
    push(PadChar, 1'b1, 1'b0);
    push("A", 1'b1, 1'b0);
    push(8'h60, 1'b1, 1'b1);

    // A stream that changes direction twice; the final flush overruns four results.
    write_mode(ModeEncode);
    push("x", 1'b1, 1'b0);
    push("x", 1'b1, 1'b0);
    write_mode(ModeDecode);
    push("A", 1'b1, 1'b0);
    push("A", 1'b1, 1'b0);
    push("A", 1'b1, 1'b0);
    push("@", 1'b1, 1'b0);
    write_mode(ModeEncode);
    push(8'h81, 1'b1, 1'b1);

    for (int regime = 0; regime < 3; regime++) begin
      tx_pct = (regime == 0) ? 29 : (regime == 1) ? 58 : 0;
      rx_pct = (regime == 0) ? 58 : (regime == 1) ? 29 : 0;
      useful = 0;
      while (useful < RandomPerRegime) begin
        r = $urandom_range(99);
        if (r < 4) begin
          write_mode(($urandom_range(3) == 0) ? cur_mode : ~cur_mode);
        end else if (r < 6) begin
          drain();
        end else if (r < 9) begin
          push(8'($urandom_range(255)), 1'b0, 1'b0);
        end else if (r < 27) begin
          push(pick_value(), 1'($urandom_range(1)), 1'b1);
          useful++;
        end else begin
          push(pick_value(), 1'b1, 1'b0);
          useful++;
        end
      end
    end
    push(pick_value(), 1'b0, 1'b1);

    item_valid <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 50000 && outstanding != 0; k++) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("Sent %0d encode and %0d decode transactions in %0d streams, %0d results checked.",
             encode_items, decode_items, stream_ends, results_checked);
    $display("Direction register written %0d times over three pacing regimes.", mode_writes);
    if (mismatches == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/b64u_pkg.sv
src/b64u_front.sv
src/b64u_queue.sv
src/b64u_back.sv
src/base64url_stream_codec.sv
bench/base64url_stream_codec_checker.sv
bench/base64url_stream_codec_tb.sv
